/* rtl/core/object_relocation_patcher_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the relocation patcher core
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef OBJECT_RELOCATION_PATCHER_CORE_DEFINES_SVH
`define OBJECT_RELOCATION_PATCHER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ORP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ORP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/orp_pkg.sv */
// ----------------------------------------------------------------------------
// orp_pkg
// Types and codes shared by the relocation patcher core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package orp_pkg;

	localparam int ApbAddrW = 1;
	localparam int ApbDataW = 32;

	typedef enum logic [1:0] {
		ARCH_X86_64 = 2'd0,
		ARCH_ARM64  = 2'd1,
		ARCH_ARM32  = 2'd2,
		ARCH_NONE   = 2'd3
	} arch_mode_t;

	// register byte addresses
	localparam logic [ApbAddrW-1:0] REG_ARCH_MODE = '0;

	// raw relocation type codes
	localparam logic [3:0] X86_UNSIGNED   = 4'd0;
	localparam logic [3:0] X86_SIGNED     = 4'd1;
	localparam logic [3:0] X86_BRANCH     = 4'd2;
	localparam logic [3:0] X86_GOT_LOAD   = 4'd3;
	localparam logic [3:0] X86_GOT        = 4'd4;
	localparam logic [3:0] A64_UNSIGNED   = 4'd0;
	localparam logic [3:0] A64_BRANCH26   = 4'd2;
	localparam logic [3:0] A64_PAGE21     = 4'd3;
	localparam logic [3:0] A64_PAGEOFF12  = 4'd4;
	localparam logic [3:0] A64_GOT_PAGE21 = 4'd5;
	localparam logic [3:0] A64_GOT_PGOFF  = 4'd6;
	localparam logic [3:0] A32_VANILLA    = 4'd0;

	// write sizes
	localparam logic [1:0] WSIZE_NONE  = 2'd0;
	localparam logic [1:0] WSIZE_FOUR  = 2'd1;
	localparam logic [1:0] WSIZE_EIGHT = 2'd2;

	// instruction field masks
	localparam logic [31:0] BR26_KEEP    = 32'hFC00_0000;
	localparam logic [31:0] PAGE21_KEEP  = 32'h9F00_001F;
	localparam logic [31:0] PAGEOFF_KEEP = 32'hFFC0_03FF;

	typedef struct packed {
		logic [3:0]  reloc_type;
		logic [63:0] symbol_address;
		logic [63:0] place_address;
		logic [63:0] existing_word;
		logic [3:0]  room_bytes;
	} cmd_t;

	typedef struct packed {
		logic [63:0] patched_word;
		logic [1:0]  write_size;
		logic        absolute_pointer;
		logic        signed_relative;
	} result_t;

endpackage

/* rtl/core/orp_apb_regs.sv */
// ----------------------------------------------------------------------------
// orp_apb_regs
// APB register file holding the architecture mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module orp_apb_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [orp_pkg::ApbAddrW-1:0]  paddr,
	input  logic [orp_pkg::ApbDataW-1:0]  pwdata,
	output logic [orp_pkg::ApbDataW-1:0]  prdata,
	output logic                          pready,
	output orp_pkg::arch_mode_t           arch_mode
);

	orp_pkg::arch_mode_t arch_q;
	logic                wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr == orp_pkg::REG_ARCH_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arch_q <= orp_pkg::ARCH_X86_64;
		end else if (wr_en) begin
			arch_q <= orp_pkg::arch_mode_t'(pwdata[1:0]);
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == orp_pkg::REG_ARCH_MODE) begin
			prdata[1:0] = arch_q;
		end
	end

	assign arch_mode = arch_q;

endmodule

/* rtl/core/orp_patch_unit.sv */
// ----------------------------------------------------------------------------
// orp_patch_unit
// Combinational relocation fixup for one registered word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module orp_patch_unit (
	input  orp_pkg::arch_mode_t arch_mode,
	input  orp_pkg::cmd_t       cmd,
	output orp_pkg::result_t    result
);

	logic [31:0] lo;
	logic [31:0] pcrel32;
	logic [63:0] abs64;
	logic [63:0] br_diff;
	logic [20:0] page_diff;
	logic [31:0] vanilla32;
	logic [31:0] word4;
	logic        four;
	logic        eight;
	logic        absf;
	logic        relf;
	logic        room4;
	logic        room8;

	assign lo        = cmd.existing_word[31:0];
	// only the low 32 bits of S + sext(lo) - P survive
	assign pcrel32   = cmd.symbol_address[31:0] + lo - cmd.place_address[31:0];
	assign abs64     = cmd.symbol_address + cmd.existing_word;
	assign br_diff   = cmd.symbol_address - cmd.place_address;
	// page delta bits [32:12]
	assign page_diff = cmd.symbol_address[32:12] - cmd.place_address[32:12];
	assign vanilla32 = cmd.symbol_address[31:0] + lo;
	assign room4     = (cmd.room_bytes >= 4'd4);
	assign room8     = (cmd.room_bytes >= 4'd8);

	always_comb begin
		word4 = lo;
		four  = 1'b0;
		eight = 1'b0;
		absf  = 1'b0;
		relf  = 1'b0;
		case (arch_mode)
			orp_pkg::ARCH_X86_64: begin
				if (cmd.reloc_type inside {orp_pkg::X86_SIGNED, orp_pkg::X86_BRANCH,
						orp_pkg::X86_GOT_LOAD, orp_pkg::X86_GOT}) begin
					word4 = pcrel32;
					four  = 1'b1;
					relf  = (cmd.reloc_type == orp_pkg::X86_SIGNED);
				end else if (cmd.reloc_type == orp_pkg::X86_UNSIGNED) begin
					eight = 1'b1;
					absf  = 1'b1;
				end
			end
			orp_pkg::ARCH_ARM64: begin
				if (cmd.reloc_type == orp_pkg::A64_UNSIGNED) begin
					eight = 1'b1;
					absf  = 1'b1;
				end else if (cmd.reloc_type == orp_pkg::A64_BRANCH26) begin
					word4 = (lo & orp_pkg::BR26_KEEP) | {6'd0, br_diff[27:2]};
					four  = 1'b1;
				end else if (cmd.reloc_type inside {orp_pkg::A64_PAGE21,
						orp_pkg::A64_GOT_PAGE21}) begin
					word4 = (lo & orp_pkg::PAGE21_KEEP)
						| {1'b0, page_diff[1:0], 5'd0, page_diff[20:2], 5'd0};
					four  = 1'b1;
				end else if (cmd.reloc_type inside {orp_pkg::A64_PAGEOFF12,
						orp_pkg::A64_GOT_PGOFF}) begin
					word4 = (lo & orp_pkg::PAGEOFF_KEEP)
						| {10'd0, cmd.symbol_address[11:0], 10'd0};
					four  = 1'b1;
				end
			end
			orp_pkg::ARCH_ARM32: begin
				if (cmd.reloc_type == orp_pkg::A32_VANILLA) begin
					word4 = vanilla32;
					four  = 1'b1;
					absf  = 1'b1;
				end
			end
			default: begin
			end
		endcase

		result.patched_word     = cmd.existing_word;
		result.write_size       = orp_pkg::WSIZE_NONE;
		result.absolute_pointer = 1'b0;
		result.signed_relative  = 1'b0;
		if (eight && room8) begin
			result.patched_word     = abs64;
			result.write_size       = orp_pkg::WSIZE_EIGHT;
			result.absolute_pointer = absf;
		end else if (four && room4) begin
			result.patched_word     = {cmd.existing_word[63:32], word4};
			result.write_size       = orp_pkg::WSIZE_FOUR;
			result.absolute_pointer = absf;
			result.signed_relative  = relf;
		end
	end

endmodule

/* rtl/core/object_relocation_patcher_core.sv */
// ----------------------------------------------------------------------------
// object_relocation_patcher_core
// Mach-O relocation fixup engine: one relocation record in, one patched word out.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd and raise start; the word is taken at a rising
//   edge with start high and busy low. busy is high only in the first cycle
//   after reset, so a new word can be issued every cycle.
//   Result channel: done is high for exactly one cycle with result valid in
//   that cycle. The receiver cannot stall; results must be captured then.
//   Latency: a taken word passes through the input register, then the result
//   register, before it shows on result/done.
//   Throughput: one word per cycle, set by the single combinational fixup
//   stage between the two registers (adds/subtracts plus masks/selects).
//   Config: APB register at byte 0 holds arch_mode (0 x86-64, 1 AArch64,
//   2 ARM32, 3 none). Write it only while no word is in flight.
//   Reset: arst_n clears arch_mode to x86-64 and drops all in-flight words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module object_relocation_patcher_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// command channel
	input  logic                          start,
	output logic                          busy,
	input  orp_pkg::cmd_t                 cmd,
	// result channel
	output logic                          done,
	output orp_pkg::result_t              result,
	// APB config port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [orp_pkg::ApbAddrW-1:0]  paddr,
	input  logic [orp_pkg::ApbDataW-1:0]  pwdata,
	output logic [orp_pkg::ApbDataW-1:0]  prdata,
	output logic                          pready
);

	orp_pkg::arch_mode_t arch_mode;
	logic                hold_q;     // one idle cycle after reset
	logic                accept;
	logic                vld_s1;
	orp_pkg::cmd_t       cmd_s1;
	orp_pkg::result_t    res_comb;
	logic                vld_s2;
	orp_pkg::result_t    res_s2;

	orp_apb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.arch_mode (arch_mode)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b1;
		end else begin
			hold_q <= 1'b0;
		end
	end

	assign busy   = hold_q;
	assign accept = start && !hold_q;

	// stage 1: capture the incoming word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
	end

	// fixup logic: type decode, adds/subtracts per kind, field merge
	orp_patch_unit u_patch (
		.arch_mode (arch_mode),
		.cmd       (cmd_s1),
		.result    (res_comb)
	);

	// stage 2: result register, strobed for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign done   = vld_s2;
	assign result = res_s2;

endmodule

/* rtl/core/orp_checker.sv */
// ----------------------------------------------------------------------------
// orp_checker
// Port-level checks on the relocation patcher core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "object_relocation_patcher_core_defines.svh"

module orp_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input orp_pkg::cmd_t    cmd,
	input logic             done,
	input orp_pkg::result_t result
);

	logic acc;

	assign acc = start && !busy;

	// every taken word yields exactly one result, through the input and result registers
	`ORP_ASSERT_NEXT(a_latency, clk, arst_n, 1'b1, done == $past(acc, 2), "done does not track accepts")

	`ORP_ASSERT_NOW(a_size_code, clk, arst_n, done, result.write_size != 2'd3, "illegal write size")

	// no write leaves the word alone and clears both flags
	`ORP_ASSERT_NOW(a_nowrite, clk, arst_n, done && (result.write_size == orp_pkg::WSIZE_NONE), !result.absolute_pointer && !result.signed_relative && (result.patched_word == $past(cmd.existing_word, 2)), "no-write result altered")

	// signed PC-relative is always a four-byte write
	`ORP_ASSERT_NOW(a_rel_four, clk, arst_n, done && result.signed_relative, (result.write_size == orp_pkg::WSIZE_FOUR) && !result.absolute_pointer, "signed-relative flag on wrong write")

	// four-byte writes keep the upper half
	`ORP_ASSERT_NOW(a_upper_kept, clk, arst_n, done && (result.write_size == orp_pkg::WSIZE_FOUR), result.patched_word[63:32] == $past(cmd.existing_word[63:32], 2), "upper half changed on four-byte write")

endmodule

bind object_relocation_patcher_core orp_checker u_orp_checker (.*);

/* dv/object_relocation_patcher_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// object_relocation_patcher_core_test
// Self-checking bench for the relocation patcher core. Relocation records are
// sent on the command channel, and each one is also run through a local
// fixup model. Each returned word is compared field by field with the oldest
// prediction. The arch_mode register is set over APB between phases, once the
// pipe has drained, and is read back each time. A directed set covers every
// relocation kind, the unknown types and the room limits. Random phases then
// follow, with a random architecture and random gaps between words.
// ----------------------------------------------------------------------------

module object_relocation_patcher_core_test;
	import orp_pkg::*;

	localparam int CLK_PERIOD      = 10;
	localparam int RESET_CYCLES    = 8;
	localparam int WATCHDOG_LIMIT  = 500;
	localparam int DRAIN_CYCLES    = 8;
	localparam int MAX_REPORTS     = 10;
	localparam int RANDOM_PHASES   = 11;
	localparam int WORDS_PER_PHASE = 50;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	cmd_t                cmd_word;
	logic                done;
	result_t             result_word;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ApbAddrW-1:0] paddr;
	logic [ApbDataW-1:0] pwdata;
	logic [ApbDataW-1:0] prdata;
	logic                pready;

	// local copy of arch_mode, updated when the APB write lands
	arch_mode_t arch_shadow;
	// predicted fixups, oldest first
	result_t    expected_patches[$];
	int         mismatch_count;
	int         watchdog_cycles;
	// when set, the sender issues back-to-back words with no gaps
	bit         burst_mode;

	object_relocation_patcher_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd_word),
		.done    (done),
		.result  (result_word),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Fixup model: one relocation record in, expected word out
	// ------------------------------------------------------------------------
	function automatic result_t predict_patch(arch_mode_t arch, cmd_t rec);
		logic [31:0] lo;
		logic [31:0] word4;
		logic [63:0] disp;
		logic        four;
		result_t     r;
		lo                 = rec.existing_word[31:0];
		word4              = '0;
		disp               = '0;
		four               = 1'b0;
		r.patched_word     = rec.existing_word;
		r.write_size       = WSIZE_NONE;
		r.absolute_pointer = 1'b0;
		r.signed_relative  = 1'b0;
		case (arch)
			ARCH_X86_64: begin
				if (rec.reloc_type == X86_UNSIGNED) begin
					if (rec.room_bytes >= 4'd8) begin
						r.patched_word     = rec.symbol_address + rec.existing_word;
						r.write_size       = WSIZE_EIGHT;
						r.absolute_pointer = 1'b1;
					end
				end else if (rec.reloc_type inside {X86_SIGNED, X86_BRANCH,
						X86_GOT_LOAD, X86_GOT}) begin
					// PC-relative: S + sext(addend) - P, low 32 bits
					disp = rec.symbol_address + {{32{lo[31]}}, lo} - rec.place_address;
					word4 = disp[31:0];
					four = 1'b1;
					r.signed_relative = (rec.reloc_type == X86_SIGNED);
				end
			end
			ARCH_ARM64: begin
				if (rec.reloc_type == A64_UNSIGNED) begin
					if (rec.room_bytes >= 4'd8) begin
						r.patched_word     = rec.symbol_address + rec.existing_word;
						r.write_size       = WSIZE_EIGHT;
						r.absolute_pointer = 1'b1;
					end
				end else if (rec.reloc_type == A64_BRANCH26) begin
					disp = rec.symbol_address - rec.place_address;
					word4 = (lo & BR26_KEEP) | {6'b0, disp[27:2]};
					four = 1'b1;
				end else if (rec.reloc_type inside {A64_PAGE21, A64_GOT_PAGE21}) begin
					// page delta split into immlo (bits 30:29) and immhi (bits 23:5)
					disp = {rec.symbol_address[63:12], 12'h000}
						- {rec.place_address[63:12], 12'h000};
					word4 = (lo & PAGE21_KEEP) | {1'b0, disp[13:12], 29'b0}
						| {8'b0, disp[32:14], 5'b0};
					four = 1'b1;
				end else if (rec.reloc_type inside {A64_PAGEOFF12, A64_GOT_PGOFF}) begin
					word4 = (lo & PAGEOFF_KEEP) | {10'b0, rec.symbol_address[11:0], 10'b0};
					four = 1'b1;
				end
			end
			ARCH_ARM32: begin
				if (rec.reloc_type == A32_VANILLA) begin
					word4 = rec.symbol_address[31:0] + lo;
					four = 1'b1;
					r.absolute_pointer = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (four) begin
			if (rec.room_bytes >= 4'd4) begin
				r.patched_word = {rec.existing_word[63:32], word4};
				r.write_size   = WSIZE_FOUR;
			end else begin
				// no room: nothing written, flags dropped
				r.absolute_pointer = 1'b0;
				r.signed_relative  = 1'b0;
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Failure reporting: first few in full, the rest only counted
	// ------------------------------------------------------------------------
	task automatic note_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("[%0t] MISMATCH %s", $realtime, msg);
	endtask

	task automatic check_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got)
			note_failure($sformatf("%s: expected 0x%0h, got 0x%0h", field, want, got));
	endtask

	// Result side: done is a one-cycle strobe, so sample every edge.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (expected_patches.size() == 0) begin
				note_failure($sformatf("word with nothing pending: 0x%0h",
					result_word.patched_word));
			end else begin
				want = expected_patches.pop_front();
				check_field("patched_word", want.patched_word, result_word.patched_word);
				check_field("write_size", want.write_size, result_word.write_size);
				check_field("absolute_pointer", want.absolute_pointer,
					result_word.absolute_pointer);
				check_field("signed_relative", want.signed_relative,
					result_word.signed_relative);
			end
		end
	end

	// Watchdog: counts cycles in which no command, result or APB access is taken.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (psel && penable && pready)) begin
			watchdog_cycles <= 0;
		end else if (watchdog_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
			$display("object_relocation_patcher_core_test NOT OK");
			$finish;
		end else begin
			watchdog_cycles <= watchdog_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst_mode || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 30);
	endfunction

	// Drive a word at the falling edge and hold it until the core takes it.
	// start stays high into the next word when there is no gap.
	task automatic send_word(input cmd_t rec);
		int gap;
		@(negedge clk);
		start    <= 1'b1;
		cmd_word <= rec;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_patches.push_back(predict_patch(arch_shadow, rec));
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// Lower start and wait until every predicted word has come back.
	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (expected_patches.size() != 0)
			@(posedge clk);
	endtask

	// APB write of arch_mode, then a read back of the same register.
	task automatic program_arch_mode(input arch_mode_t mode);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_ARCH_MODE;
		pwdata  <= {{(ApbDataW - 2){1'b0}}, mode};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		arch_shadow = mode;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		check_field("arch_mode readback", {62'b0, mode}, {{(64 - ApbDataW){1'b0}}, prdata});
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic cmd_t make_record(input logic [3:0] kind, input logic [63:0] sym,
			input logic [63:0] place, input logic [63:0] word, input logic [3:0] room);
		cmd_t rec;
		rec.reloc_type     = kind;
		rec.symbol_address = sym;
		rec.place_address  = place;
		rec.existing_word  = word;
		rec.room_bytes     = room;
		return rec;
	endfunction

	function automatic logic [63:0] random_addr();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return ALL_ONES;
			2: return {32'h0, 32'($urandom)};
			3: return {32'($urandom), 32'h0};
			default: return {32'($urandom), 32'($urandom)};
		endcase
	endfunction

	// Mostly kinds that the current architecture knows, mostly enough room.
	function automatic cmd_t random_record(input arch_mode_t arch);
		cmd_t        rec;
		logic [31:0] offset;
		int          r;
		rec.symbol_address = random_addr();
		rec.place_address  = random_addr();
		rec.existing_word  = random_addr();
		offset = $urandom;
		// target near the place, as real branches and page refs are
		if ($urandom_range(0, 3) == 0)
			rec.symbol_address = rec.place_address + {{32{offset[31]}}, offset};
		if ($urandom_range(0, 9) == 0) begin
			rec.reloc_type = 4'($urandom_range(0, 15));
		end else begin
			case (arch)
				ARCH_X86_64: rec.reloc_type = 4'($urandom_range(0, 4));
				ARCH_ARM64: begin
					case ($urandom_range(0, 5))
						0: rec.reloc_type = A64_UNSIGNED;
						1: rec.reloc_type = A64_BRANCH26;
						2: rec.reloc_type = A64_PAGE21;
						3: rec.reloc_type = A64_PAGEOFF12;
						4: rec.reloc_type = A64_GOT_PAGE21;
						default: rec.reloc_type = A64_GOT_PGOFF;
					endcase
				end
				ARCH_ARM32: rec.reloc_type = A32_VANILLA;
				default: rec.reloc_type = 4'($urandom_range(0, 15));
			endcase
		end
		r = $urandom_range(0, 19);
		if (r < 14)
			rec.room_bytes = 4'd8;
		else if (r < 18)
			rec.room_bytes = 4'($urandom_range(0, 7));
		else
			rec.room_bytes = 4'($urandom_range(9, 15));
		return rec;
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Runs on the reset value of arch_mode (x86-64), with no write first.
	task automatic test_x86_after_reset();
		send_word(make_record(X86_UNSIGNED, ALL_ONES, 64'h0, 64'h2, 4'd8));
		// negative addend, upper half of the word must survive
		send_word(make_record(X86_SIGNED, 64'h1000, 64'h2000,
			64'hFFFF_FFFF_FFFF_FFF0, 4'd4));
		send_word(make_record(X86_BRANCH, ALL_ONES, 64'h0, 64'h7FFF_FFFF, 4'd8));
		send_word(make_record(X86_GOT_LOAD, random_addr(), random_addr(),
			random_addr(), 4'd15));
		send_word(make_record(X86_GOT, 64'h0, ALL_ONES, 64'h8000_0000, 4'd8));
		send_word(make_record(4'd5, random_addr(), random_addr(), random_addr(), 4'd8));
		send_word(make_record(4'd15, ALL_ONES, ALL_ONES, ALL_ONES, 4'd15));
	endtask

	task automatic test_arm64_kinds();
		wait_idle();
		program_arch_mode(ARCH_ARM64);
		send_word(make_record(A64_UNSIGNED, ALL_ONES, ALL_ONES, ALL_ONES, 4'd8));
		// backward branch and a branch that wraps the address space
		send_word(make_record(A64_BRANCH26, 64'h1_0000_0000, 64'h1_0000_0004,
			64'h9400_0000, 4'd4));
		send_word(make_record(A64_BRANCH26, 64'h0, ALL_ONES, ALL_ONES, 4'd8));
		send_word(make_record(A64_PAGE21, ALL_ONES, 64'h0, 64'h9000_0000, 4'd8));
		send_word(make_record(A64_GOT_PAGE21, random_addr(), random_addr(),
			ALL_ONES, 4'd4));
		send_word(make_record(A64_PAGEOFF12, 64'hFFF, 64'h0, ALL_ONES, 4'd8));
		send_word(make_record(A64_GOT_PGOFF, random_addr(), random_addr(), 64'h0, 4'd8));
		send_word(make_record(4'd1, random_addr(), random_addr(), random_addr(), 4'd8));
		send_word(make_record(4'd7, random_addr(), random_addr(), random_addr(), 4'd8));
	endtask

	task automatic test_arm32_vanilla();
		wait_idle();
		program_arch_mode(ARCH_ARM32);
		send_word(make_record(A32_VANILLA, ALL_ONES, 64'h0, 64'hAAAA_AAAA_0000_0001, 4'd4));
		send_word(make_record(4'd1, random_addr(), random_addr(), random_addr(), 4'd8));
	endtask

	// arch_mode none: nothing is ever written
	task automatic test_no_arch();
		wait_idle();
		program_arch_mode(ARCH_NONE);
		send_word(make_record(4'd0, ALL_ONES, 64'h0, ALL_ONES, 4'd8));
		send_word(make_record(4'd2, random_addr(), random_addr(), random_addr(), 4'd15));
	endtask

	// Room checks: eight-byte kinds need 8, four-byte kinds need 4, above 8 is plenty.
	task automatic test_room_limits();
		wait_idle();
		program_arch_mode(ARCH_X86_64);
		send_word(make_record(X86_UNSIGNED, random_addr(), random_addr(),
			random_addr(), 4'd7));
		send_word(make_record(X86_SIGNED, random_addr(), random_addr(),
			random_addr(), 4'd3));
		send_word(make_record(X86_SIGNED, random_addr(), random_addr(),
			random_addr(), 4'd0));
		send_word(make_record(X86_SIGNED, random_addr(), random_addr(),
			random_addr(), 4'd4));
		send_word(make_record(X86_UNSIGNED, random_addr(), random_addr(),
			random_addr(), 4'd15));
	endtask

	// Random phases: every architecture first, then random ones.
	task automatic test_random_mix();
		arch_mode_t mode;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_idle();
			mode = (phase < 4) ? arch_mode_t'(phase) : arch_mode_t'($urandom_range(0, 3));
			program_arch_mode(mode);
			burst_mode = ($urandom_range(0, 3) == 0);
			repeat (WORDS_PER_PHASE)
				send_word(random_record(arch_shadow));
			burst_mode = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		cmd_word       = '0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		arch_shadow    = ARCH_X86_64;
		mismatch_count = 0;
		burst_mode     = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_x86_after_reset();
		test_arm64_kinds();
		test_arm32_vanilla();
		test_no_arch();
		test_room_limits();
		test_random_mix();

		// let the pipe drain, then a few more cycles for stray strobes
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_patches.size() == 0)
			$display("object_relocation_patcher_core_test OK");
		else
			$display("object_relocation_patcher_core_test NOT OK");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/orp_pkg.sv
rtl/core/orp_apb_regs.sv
rtl/core/orp_patch_unit.sv
rtl/core/object_relocation_patcher_core.sv
rtl/core/orp_checker.sv
dv/object_relocation_patcher_core_test.sv
